/* rtl/core/y86fd_pkg.sv */
// ----------------------------------------------------------------------------
// y86fd_pkg
// Types and constants shared by the Y86-64 fetch/decode block.
// ----------------------------------------------------------------------------
package y86fd_pkg;

  localparam int PC_W       = 16;
  // pc plus the longest bound offset needs one extra bit
  localparam int PC_EXT_W   = PC_W + 1;
  localparam int MEM_SIZE_DEFAULT = 8192;

  typedef enum logic [3:0] {
    K_HALT    = 4'd0,
    K_NOP     = 4'd1,
    K_CMOV    = 4'd2,
    K_IRMOVQ  = 4'd3,
    K_RMMOVQ  = 4'd4,
    K_MRMOVQ  = 4'd5,
    K_OPQ     = 4'd6,
    K_JUMP    = 4'd7,
    K_CALL    = 4'd8,
    K_RET     = 4'd9,
    K_PUSH    = 4'd10,
    K_POP     = 4'd11,
    K_INVALID = 4'd12
  } kind_t;

  typedef enum logic [1:0] {
    ST_AOK = 2'd0,
    ST_HLT = 2'd1,
    ST_ADR = 2'd2,
    ST_INS = 2'd3
  } status_t;

  localparam logic [7:0] OP_HALT     = 8'h00;
  localparam logic [7:0] OP_NOP      = 8'h10;
  localparam logic [7:0] OP_CMOV_LO  = 8'h20;
  localparam logic [7:0] OP_CMOV_HI  = 8'h26;
  localparam logic [7:0] OP_IRMOVQ   = 8'h30;
  localparam logic [7:0] OP_RMMOVQ   = 8'h40;
  localparam logic [7:0] OP_MRMOVQ   = 8'h50;
  localparam logic [7:0] OP_OPQ_LO   = 8'h60;
  localparam logic [7:0] OP_OPQ_HI   = 8'h63;
  localparam logic [7:0] OP_JUMP_LO  = 8'h70;
  localparam logic [7:0] OP_JUMP_HI  = 8'h76;
  localparam logic [7:0] OP_CALL     = 8'h80;
  localparam logic [7:0] OP_RET      = 8'h90;
  localparam logic [7:0] OP_PUSH     = 8'hA0;
  localparam logic [7:0] OP_POP      = 8'hB0;

  localparam logic [3:0] REG_NONE    = 4'hF;
  localparam logic [3:0] REG_MAX     = 4'd14;

  // bytes past the opcode that must still lie inside memory
  localparam logic [3:0] EXTRA_CMOV   = 4'd1;
  localparam logic [3:0] EXTRA_RMMOVQ = 4'd9;
  localparam logic [3:0] EXTRA_CALL   = 4'd8;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic [7:0]      opcode_byte;
    logic [63:0]     bytes_one_to_eight;
    logic [7:0]      byte_nine;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  func_code;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [63:0] constant_value;
    logic [3:0]  length;
    status_t     status;
  } out_item_t;

endpackage

/* rtl/core/y86fd_decode.sv */
// ----------------------------------------------------------------------------
// y86fd_decode
// Combinational decode of one instruction: kind, fields, length, status.
// ----------------------------------------------------------------------------
module y86fd_decode #(
  parameter int MEM_SIZE = y86fd_pkg::MEM_SIZE_DEFAULT
) (
  input  y86fd_pkg::in_item_t  item,
  output y86fd_pkg::out_item_t result
);

  localparam logic [y86fd_pkg::PC_EXT_W-1:0] MEM_LIMIT = y86fd_pkg::PC_EXT_W'(MEM_SIZE);

  logic [y86fd_pkg::PC_EXT_W-1:0] pc_ext;
  logic [7:0]  op;
  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [63:0] disp;
  logic        fit_cmov;
  logic        fit_rmmovq;
  logic        fit_call;

  assign pc_ext = {1'b0, item.pc};
  assign op     = item.opcode_byte;
  assign hi     = item.bytes_one_to_eight[7:4];
  assign lo     = item.bytes_one_to_eight[3:0];
  // displacement / immediate lives in bytes 2..9
  assign disp   = {item.byte_nine, item.bytes_one_to_eight[63:8]};

  assign fit_cmov   = (pc_ext + y86fd_pkg::PC_EXT_W'(y86fd_pkg::EXTRA_CMOV))   < MEM_LIMIT;
  assign fit_rmmovq = (pc_ext + y86fd_pkg::PC_EXT_W'(y86fd_pkg::EXTRA_RMMOVQ)) < MEM_LIMIT;
  assign fit_call   = (pc_ext + y86fd_pkg::PC_EXT_W'(y86fd_pkg::EXTRA_CALL))   < MEM_LIMIT;

  always_comb begin
    result.kind           = y86fd_pkg::K_INVALID;
    result.func_code      = 3'd0;
    result.reg_a          = 4'd0;
    result.reg_b          = 4'd0;
    result.constant_value = 64'd0;
    result.length         = 4'd0;
    result.status         = y86fd_pkg::ST_INS;

    if (pc_ext >= MEM_LIMIT) begin
      result.status = y86fd_pkg::ST_ADR;
    end else if (op == y86fd_pkg::OP_HALT) begin
      result.kind   = y86fd_pkg::K_HALT;
      result.length = 4'd1;
      result.status = y86fd_pkg::ST_HLT;
    end else if (op == y86fd_pkg::OP_NOP) begin
      result.kind   = y86fd_pkg::K_NOP;
      result.length = 4'd1;
      result.status = y86fd_pkg::ST_AOK;
    end else if (op inside {[y86fd_pkg::OP_CMOV_LO:y86fd_pkg::OP_CMOV_HI]}) begin
      if (!fit_cmov) begin
        result.status = y86fd_pkg::ST_ADR;
      end else begin
        result.kind      = y86fd_pkg::K_CMOV;
        result.func_code = op[2:0];
        result.reg_a     = hi;
        result.reg_b     = lo;
        result.length    = 4'd2;
        result.status    = y86fd_pkg::ST_AOK;
      end
    end else if (op == y86fd_pkg::OP_IRMOVQ) begin
      // bad register byte keeps regs and length, drops the immediate
      result.reg_a  = hi;
      result.reg_b  = lo;
      result.length = 4'd10;
      if (hi == y86fd_pkg::REG_NONE && lo <= y86fd_pkg::REG_MAX) begin
        result.kind           = y86fd_pkg::K_IRMOVQ;
        result.constant_value = disp;
        result.status         = y86fd_pkg::ST_AOK;
      end
    end else if (op == y86fd_pkg::OP_RMMOVQ) begin
      if (!fit_rmmovq) begin
        result.status = y86fd_pkg::ST_ADR;
      end else begin
        result.kind           = y86fd_pkg::K_RMMOVQ;
        result.reg_a          = hi;
        result.reg_b          = lo;
        result.length         = 4'd10;
        result.constant_value = disp;
        result.status         = y86fd_pkg::ST_AOK;
      end
    end else if (op == y86fd_pkg::OP_MRMOVQ) begin
      result.kind           = y86fd_pkg::K_MRMOVQ;
      result.reg_a          = hi;
      result.reg_b          = lo;
      result.length         = 4'd10;
      result.constant_value = disp;
      result.status         = y86fd_pkg::ST_AOK;
    end else if (op inside {[y86fd_pkg::OP_OPQ_LO:y86fd_pkg::OP_OPQ_HI]}) begin
      result.kind      = y86fd_pkg::K_OPQ;
      result.func_code = op[2:0];
      result.reg_a     = hi;
      result.reg_b     = lo;
      result.length    = 4'd2;
      result.status    = y86fd_pkg::ST_AOK;
    end else if (op inside {[y86fd_pkg::OP_JUMP_LO:y86fd_pkg::OP_JUMP_HI]}) begin
      result.kind           = y86fd_pkg::K_JUMP;
      result.func_code      = op[2:0];
      result.length         = 4'd9;
      result.constant_value = item.bytes_one_to_eight;
      result.status         = y86fd_pkg::ST_AOK;
    end else if (op == y86fd_pkg::OP_CALL) begin
      if (!fit_call) begin
        result.status = y86fd_pkg::ST_ADR;
      end else begin
        result.kind           = y86fd_pkg::K_CALL;
        result.length         = 4'd9;
        result.constant_value = item.bytes_one_to_eight;
        result.status         = y86fd_pkg::ST_AOK;
      end
    end else if (op == y86fd_pkg::OP_RET) begin
      result.kind   = y86fd_pkg::K_RET;
      result.length = 4'd1;
      result.status = y86fd_pkg::ST_AOK;
    end else if (op == y86fd_pkg::OP_PUSH || op == y86fd_pkg::OP_POP) begin
      result.reg_a  = hi;
      result.reg_b  = lo;
      result.length = 4'd2;
      if (lo == y86fd_pkg::REG_NONE) begin
        result.kind   = (op == y86fd_pkg::OP_PUSH) ? y86fd_pkg::K_PUSH : y86fd_pkg::K_POP;
        result.status = y86fd_pkg::ST_AOK;
      end
    end
  end

endmodule

/* rtl/core/y86_fetch_decode.sv */
// ----------------------------------------------------------------------------
// y86_fetch_decode
// Decodes one Y86-64 instruction per cycle from pc and ten fetched bytes.
//
//   channel   direction  handshake              payload
//   item      in         start && !busy         in_item_t
//   result    out        done (one cycle)       out_item_t
//
// Path: input register, combinational decode, result register.
// One item per cycle; busy is never raised, so start is taken every cycle.
// Reset clears the valid flags only; payload registers are not reset.
// The receiver cannot stall: each result shows for one cycle with done.
// ----------------------------------------------------------------------------
module y86_fetch_decode #(
  parameter int MEM_SIZE = y86fd_pkg::MEM_SIZE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  y86fd_pkg::in_item_t  item,
  output logic                 done,
  output y86fd_pkg::out_item_t result
);

  logic                 in_valid;
  y86fd_pkg::in_item_t  in_reg;
  y86fd_pkg::out_item_t result_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_reg <= item;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  y86fd_decode #(
    .MEM_SIZE(MEM_SIZE)
  ) u_decode (
    .item   (in_reg),
    .result (result_next)
  );

endmodule
